// File: rtl/core/pfs_pkg.sv
`timescale 1ns / 1ps
package pfs_pkg;

  localparam int PALETTE_ENTRIES = 256;
  localparam int IDX_W = $clog2(PALETTE_ENTRIES);
  localparam int TICK_W = 17;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [2:0] CMD_LOAD = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_TICK = 3'd2;
  localparam logic [2:0] CMD_SKIP = 3'd3;
  localparam logic [2:0] CMD_READ = 3'd4;

  localparam logic [1:0] PH_FADE_IN = 2'd0;
  localparam logic [1:0] PH_HOLD = 2'd1;
  localparam logic [1:0] PH_FADE_OUT = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FADE_IN_TICKS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEPS_PER_TICK = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CUE_ENABLE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CUE_TICK = 3'd4;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] entry_index;
    logic [7:0] target_red;
    logic [7:0] target_green;
    logic [7:0] target_blue;
  } pfs_in_t;

  typedef struct packed {
    logic [1:0] phase;
    logic       finished;
    logic       cue_pulse;
    logic [7:0] entry_red;
    logic [7:0] entry_green;
    logic [7:0] entry_blue;
  } pfs_out_t;

  typedef struct packed {
    logic accept;
    logic sweep_rd;
    logic sweep_end;
    logic read_cap;
  } ctl_cmd_t;

  typedef struct packed {
    logic [1:0] phase;
    logic       sweep_last;
  } ctl_sts_t;

endpackage

// File: rtl/core/pfs_ctrl.sv
`timescale 1ns / 1ps
module pfs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  output logic              done_o,
  input  logic [2:0]        command_i,
  input  pfs_pkg::ctl_sts_t sts_i,
  output pfs_pkg::ctl_cmd_t ctl_o
);
  import pfs_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SWEEP = 5'b00010,
    ST_DRAIN = 5'b00100,
    ST_READ  = 5'b01000,
    ST_RESP  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    ctl_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          ctl_o.accept = 1'b1;
          if (command_i == CMD_TICK &&
              (sts_i.phase == PH_FADE_IN || sts_i.phase == PH_FADE_OUT)) begin
            state_d = ST_SWEEP;
          end else if (command_i == CMD_READ) begin
            state_d = ST_READ;
          end else begin
            state_d = ST_RESP;
          end
        end
      end
      ST_SWEEP: begin
        ctl_o.sweep_rd = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        ctl_o.sweep_end = 1'b1;
        state_d = ST_RESP;
      end
      ST_READ: begin
        ctl_o.read_cap = 1'b1;
        state_d = ST_RESP;
      end
      ST_RESP: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != ST_IDLE);
  assign done_o = (state_q == ST_RESP);

endmodule

// File: rtl/core/pfs_datapath.sv
`timescale 1ns / 1ps
module pfs_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pfs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pfs_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  pfs_pkg::pfs_in_t               in_i,
  input  pfs_pkg::ctl_cmd_t              ctl_i,
  output pfs_pkg::ctl_sts_t              sts_o,
  output pfs_pkg::pfs_out_t              res_o
);
  import pfs_pkg::*;

  localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

  logic [15:0] hold_ticks_q;
  logic [7:0]  fade_in_ticks_q;
  logic [7:0]  steps_q;
  logic        cue_enable_q;
  logic [7:0]  cue_tick_q;

  logic [23:0] cur_mem [PALETTE_ENTRIES];
  logic [23:0] tgt_mem [PALETTE_ENTRIES];
  logic [PALETTE_ENTRIES-1:0] valid_q;

  logic [1:0]        phase_q;
  logic [TICK_W-1:0] tick_q;
  logic [TICK_W-1:0] tick_inc;
  logic              lower_q;
  logic              cue_q;
  logic              nz_q;
  logic              in_range_q;
  logic [23:0]       entry_q;

  logic [IDX_W-1:0] sweep_addr_q;
  logic [IDX_W-1:0] raddr;
  logic [IDX_W-1:0] wr_addr_q;
  logic             wr_pend_q;
  logic [23:0]      rd_cur_q;
  logic [23:0]      rd_tgt_q;
  logic             rd_vld_q;
  logic [23:0]      cur_pix;
  logic [23:0]      new_pix;
  logic             pix_nz;
  logic             in_range;
  logic [IDX_W-1:0] in_addr;

  function automatic logic [7:0] step_chan(input logic [7:0] cur, input logic [7:0] tgt,
                                           input logic [7:0] steps, input logic lower);
    logic [7:0] gap;
    logic [7:0] res;
    gap = tgt - cur;
    res = cur;
    if (lower) begin
      res = (cur < steps) ? 8'd0 : cur - steps;
    end else if (cur < tgt) begin
      res = cur + ((gap < steps) ? gap : steps);
    end
    return res;
  endfunction

  assign in_range = (32'(in_i.entry_index) < 32'(PALETTE_ENTRIES));
  assign in_addr = IDX_W'(in_i.entry_index);
  assign raddr = ctl_i.sweep_rd ? sweep_addr_q : in_addr;
  assign tick_inc = (tick_q == TICK_MAX) ? tick_q : tick_q + 1'b1;
  assign cur_pix = rd_vld_q ? rd_cur_q : 24'd0;
  assign pix_nz = (cur_pix != 24'd0);

  always_comb begin
    new_pix[23:16] = step_chan(cur_pix[23:16], rd_tgt_q[23:16], steps_q, lower_q);
    new_pix[15:8] = step_chan(cur_pix[15:8], rd_tgt_q[15:8], steps_q, lower_q);
    new_pix[7:0] = step_chan(cur_pix[7:0], rd_tgt_q[7:0], steps_q, lower_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_ticks_q <= 16'd0;
      fade_in_ticks_q <= 8'd64;
      steps_q <= 8'd8;
      cue_enable_q <= 1'b0;
      cue_tick_q <= 8'd32;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_HOLD_TICKS: hold_ticks_q <= cfg_data_i;
        CFG_FADE_IN_TICKS: fade_in_ticks_q <= cfg_data_i[7:0];
        CFG_STEPS_PER_TICK: steps_q <= cfg_data_i[7:0];
        CFG_CUE_ENABLE: cue_enable_q <= cfg_data_i[0];
        CFG_CUE_TICK: cue_tick_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.accept && in_i.command == CMD_LOAD && in_range) begin
      tgt_mem[in_addr] <= {in_i.target_red, in_i.target_green, in_i.target_blue};
    end
    rd_tgt_q <= tgt_mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (wr_pend_q) begin
      cur_mem[wr_addr_q] <= new_pix;
    end
    rd_cur_q <= cur_mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= valid_q[raddr];
      if (ctl_i.accept && in_i.command == CMD_START) begin
        valid_q <= '0;
      end else if (wr_pend_q) begin
        valid_q[wr_addr_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_pend_q <= 1'b0;
      sweep_addr_q <= '0;
    end else begin
      wr_pend_q <= ctl_i.sweep_rd;
      if (ctl_i.accept) begin
        sweep_addr_q <= '0;
      end else if (ctl_i.sweep_rd) begin
        sweep_addr_q <= sweep_addr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    wr_addr_q <= sweep_addr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FADE_IN;
      tick_q <= '0;
    end else if (ctl_i.accept) begin
      unique case (in_i.command)
        CMD_START: begin
          phase_q <= PH_FADE_IN;
          tick_q <= '0;
        end
        CMD_SKIP: begin
          if (phase_q != PH_DONE) begin
            phase_q <= PH_FADE_OUT;
            tick_q <= '0;
          end
        end
        CMD_TICK: begin
          if (phase_q == PH_FADE_IN && tick_inc > TICK_W'(fade_in_ticks_q)) begin
            phase_q <= PH_HOLD;
            tick_q <= '0;
          end else if (phase_q == PH_HOLD && tick_inc > TICK_W'(hold_ticks_q)) begin
            phase_q <= PH_FADE_OUT;
            tick_q <= '0;
          end else begin
            tick_q <= tick_inc;
          end
        end
        default: ;
      endcase
    end else if (ctl_i.sweep_end && lower_q && !(nz_q || pix_nz)) begin
      phase_q <= PH_DONE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.accept) begin
      lower_q <= (phase_q == PH_FADE_OUT);
      cue_q <= (in_i.command == CMD_TICK) && (phase_q == PH_FADE_IN) && cue_enable_q &&
               (tick_inc == TICK_W'(cue_tick_q));
      nz_q <= 1'b0;
      in_range_q <= in_range;
      entry_q <= 24'd0;
    end else begin
      if (wr_pend_q) begin
        nz_q <= nz_q | pix_nz;
      end
      if (ctl_i.read_cap) begin
        entry_q <= in_range_q ? cur_pix : 24'd0;
      end
    end
  end

  assign sts_o.phase = phase_q;
  assign sts_o.sweep_last = (sweep_addr_q == IDX_W'(PALETTE_ENTRIES - 1));

  assign res_o.phase = phase_q;
  assign res_o.finished = (phase_q == PH_DONE);
  assign res_o.cue_pulse = cue_q;
  assign res_o.entry_red = entry_q[23:16];
  assign res_o.entry_green = entry_q[15:8];
  assign res_o.entry_blue = entry_q[7:0];

endmodule

// File: rtl/core/palette_fade_sequencer_core.sv
`timescale 1ns / 1ps
// Palette fade engine with a target palette and a current palette of 256 RGB entries.
// A command transfer is taken at a rising edge where start is high and busy is low;
// cmd_i carries the command, the entry index and the target color for a load.
// Every command yields exactly one result on res_o, marked by done_o for one cycle.
// The receiver cannot stall: the result is taken in the cycle that done_o is high,
// and busy stays high until that cycle is over.
// Load, start, skip and ticks in hold or done go from the accepting edge straight
// to the result state; a read passes through a capture state first.
// A tick in fade in or fade out walks the current palette one entry per cycle over
// the single-port read of the palette memories and then drains before the result.
// A new command can be taken in the cycle after the result, so commands never
// overlap: the next one is not taken before the last one's result.
// Configuration writes on cfg_we_i, cfg_idx_i and cfg_data_i land at once; the user
// must make them while busy is low, as the block itself does not enforce it.
// Reset restores the register defaults, marks every current entry as black through
// per-entry valid flops, and sets the phase to fade in; target entries are undefined
// until loaded.
module palette_fade_sequencer_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  pfs_pkg::pfs_in_t               cmd_i,
  output logic                           done_o,
  output pfs_pkg::pfs_out_t              res_o,
  input  logic                           cfg_we_i,
  input  logic [pfs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pfs_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import pfs_pkg::*;

  ctl_cmd_t ctl;
  ctl_sts_t sts;

  pfs_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .done_o    (done_o),
    .command_i (cmd_i.command),
    .sts_i     (sts),
    .ctl_o     (ctl)
  );

  pfs_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (cmd_i),
    .ctl_i      (ctl),
    .sts_o      (sts),
    .res_o      (res_o)
  );

endmodule
